[src/pursuit_velocity_controller_core_macros.svh]
// ----------------------------------------------------------------------------
// Pursuit velocity controller assertion macros
// Concurrent check macros on clk and rst_n; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PURSUIT_VELOCITY_CONTROLLER_CORE_MACROS_SVH
`define PURSUIT_VELOCITY_CONTROLLER_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define PVC_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvc check failed");
// next-cycle implication
`define PVC_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvc check failed");
`else
`define PVC_CHECK(label, ante, cons)
`define PVC_CHECK_NEXT(label, ante, cons)
`endif
`endif

[src/pvc_pkg.sv]
// ----------------------------------------------------------------------------
// Pursuit velocity controller package
// Shared widths, opcodes, register indexes, angle constants and CORDIC table.
// ----------------------------------------------------------------------------
package pvc_pkg;

    // item opcodes (tuser)
    localparam logic OP_TARGET = 1'b0;
    localparam logic OP_POSE   = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_GAIN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DES_DIST = 8'd3;

    // shared multiplier operand widths
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 34;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // angles in Q2.30, 34-bit signed
    localparam int Z_W = 34;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;

    // 1/K of the CORDIC gain, Q2.30
    localparam logic [MUL_B_W-1:0] INV_K_Q30 = 34'd652032874;

    // arctan(2^-i) in Q2.30
    localparam logic [29:0] ATAN_Q30 [0:31] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
        30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
        30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
        30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
        30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
        30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008,
        30'h00000004, 30'h00000002, 30'h00000001, 30'h00000000
    };

    // request to the shared multiplier
    typedef struct packed {
        logic               load;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } pvc_mul_req_t;

endpackage

[src/pvc_mul.sv]
// ----------------------------------------------------------------------------
// Pursuit velocity controller shared multiplier
// Unsigned 20 x 34 multiplier with a registered product, loaded on request.
// ----------------------------------------------------------------------------
module pvc_mul
(
    input  logic                          clk,
    input  pvc_pkg::pvc_mul_req_t         req,
    output logic [pvc_pkg::MUL_P_W-1:0]   prod
);

    logic [pvc_pkg::MUL_P_W-1:0] prod_reg;
    logic [pvc_pkg::MUL_P_W-1:0] prod_next;

    // full-width product of the two operands
    assign prod_next = {{pvc_pkg::MUL_B_W{1'b0}}, req.a} * {{pvc_pkg::MUL_A_W{1'b0}}, req.b};

    // product register, held until the next load
    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[src/pursuit_velocity_controller_core.sv]
// Result: a position item's result is valid once the CORDIC loop and the divider finish;
// a target item is taken and gives no result.
// Items: one position item at a time, as the CORDIC loop and the 20-step restoring
// divider share one sequencer; s_tready is low meanwhile, and for longer while a
// finished result waits on m_tready.
// Reset: control and configuration registers return to their defaults, no target held, no output pending.
// ----------------------------------------------------------------------------
// Pursuit velocity controller core
// Proportional pursuit: CORDIC bearing and distance, divided linear command,
// scaled angular command, on a small sequencer and one shared multiplier.
// ----------------------------------------------------------------------------
`include "pursuit_velocity_controller_core_macros.svh"

module pursuit_velocity_controller_core
#(
    parameter int CORDIC_STEPS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] pos_x, [63:32] pos_y
    input  logic        s_tuser,   // [0] opcode
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] linear_cmd, [63:32] angular_cmd
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pvc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int ITERS  = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int IW     = (ITERS > 1) ? $clog2(ITERS) : 1;
    localparam int XW     = 36;
    localparam int DW     = 34;
    localparam int LIN_W  = 20;
    localparam int DIV_CW = $clog2(LIN_W);
    localparam int ZW     = pvc_pkg::Z_W;
    localparam int PW     = pvc_pkg::MUL_P_W;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIFF   = 4'd1;
    localparam logic [3:0] S_ROT    = 4'd2;
    localparam logic [3:0] S_CORDIC = 4'd3;
    localparam logic [3:0] S_MLO    = 4'd4;
    localparam logic [3:0] S_MHI    = 4'd5;
    localparam logic [3:0] S_DIST   = 4'd6;
    localparam logic [3:0] S_NUM    = 4'd7;
    localparam logic [3:0] S_ABS    = 4'd8;
    localparam logic [3:0] S_MULN   = 4'd9;
    localparam logic [3:0] S_DINIT  = 4'd10;
    localparam logic [3:0] S_DIV    = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [IW-1:0]     iter_reg, iter_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              target_valid_reg, target_valid_next;

    // configuration registers
    logic [19:0] max_lin_reg, max_lin_next;
    logic [19:0] ang_gain_reg, ang_gain_next;
    logic [30:0] min_dist_reg, min_dist_next;
    logic [30:0] des_dist_reg, des_dist_next;

    // datapath registers
    logic signed [31:0]   target_x_reg, target_y_reg;
    logic signed [31:0]   pos_x_reg, pos_y_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [31:0]          zmag_reg;
    logic                 zneg_reg;
    logic [PW-1:0]        acc_reg;
    logic [DW-1:0]        d_reg;
    logic signed [DW:0]   num_reg;
    logic [DW-1:0]        nmag_reg;
    logic                 lin_neg_reg;
    logic                 stop_reg;
    logic                 big_reg;
    logic [DW-1:0]        rem_reg;
    logic [LIN_W-1:0]     low_reg;
    logic [LIN_W-1:0]     quo_reg;
    logic [63:0]          out_data_reg;

    // shared multiplier
    pvc_pkg::pvc_mul_req_t mul_req;
    logic [PW-1:0]         prod;

    // combinational helpers
    logic                 s_accept;
    logic                 out_load;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] atan_step;
    logic [65:0]          dist_sum;
    logic [DW+1:0]        trial;
    logic [LIN_W-1:0]     lin_mag;
    logic [31:0]          lin_val;
    logic [PW-1:0]        ang_sum;
    logic [23:0]          ang_mag;
    logic [31:0]          ang_val;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || m_tready);

    pvc_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // multiplier operand selection
    always_comb
    begin
        mul_req.load = 1'b0;
        mul_req.a    = '0;
        mul_req.b    = '0;
        unique case (state_reg)
            S_MLO:
            begin
                mul_req.load = 1'b1;
                mul_req.a    = x_reg[19:0];
                mul_req.b    = pvc_pkg::INV_K_Q30;
            end
            S_MHI:
            begin
                mul_req.load = 1'b1;
                mul_req.a    = {5'b0, x_reg[34:20]};
                mul_req.b    = pvc_pkg::INV_K_Q30;
            end
            S_MULN:
            begin
                mul_req.load = 1'b1;
                mul_req.a    = max_lin_reg;
                mul_req.b    = nmag_reg;
            end
            S_DINIT:
            begin
                mul_req.load = 1'b1;
                mul_req.a    = ang_gain_reg;
                mul_req.b    = {2'b0, zmag_reg};
            end
            default:
            begin
                mul_req.load = 1'b0;
            end
        endcase
    end

    // CORDIC step operands
    assign xs        = x_reg >>> iter_reg;
    assign ys        = y_reg >>> iter_reg;
    assign atan_step = {4'b0, pvc_pkg::ATAN_Q30[5'(iter_reg)]};

    // distance: (x * 1/K + half) >> 30, from two partial products
    // (the upper partial product stays below 2^46)
    assign dist_sum = {12'b0, acc_reg} + {prod[45:0], 20'b0} + 66'(32'h2000_0000);

    // restoring divider trial subtract
    assign trial = {1'b0, rem_reg, low_reg[LIN_W-1]} - {2'b0, d_reg};

    // final commands
    assign lin_mag = (big_reg || (quo_reg > max_lin_reg)) ? max_lin_reg : quo_reg;
    assign lin_val = lin_neg_reg ? (32'd0 - {12'b0, lin_mag}) : {12'b0, lin_mag};
    assign ang_sum = prod + PW'(32'h2000_0000);
    assign ang_mag = ang_sum[PW-1:30];
    assign ang_val = zneg_reg ? (32'd0 - {8'b0, ang_mag}) : {8'b0, ang_mag};

    // sequencer and configuration next state
    always_comb
    begin
        state_next        = state_reg;
        iter_next         = iter_reg;
        cnt_next          = cnt_reg;
        target_valid_next = target_valid_reg;
        out_valid_next    = out_valid_reg;
        max_lin_next      = max_lin_reg;
        ang_gain_next     = ang_gain_reg;
        min_dist_next     = min_dist_reg;
        des_dist_next     = des_dist_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pvc_pkg::CFG_MAX_LIN:  max_lin_next  = cfg_data[19:0];
                pvc_pkg::CFG_ANG_GAIN: ang_gain_next = cfg_data[19:0];
                pvc_pkg::CFG_MIN_DIST: min_dist_next = cfg_data[30:0];
                pvc_pkg::CFG_DES_DIST: des_dist_next = cfg_data[30:0];
                default:               max_lin_next  = max_lin_reg;
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser == pvc_pkg::OP_TARGET)
                    begin
                        target_valid_next = 1'b1;
                    end
                    else if (target_valid_reg)
                    begin
                        state_next = S_DIFF;
                    end
                end
            end
            S_DIFF:  state_next = S_ROT;
            S_ROT:
            begin
                iter_next  = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                if (iter_reg == IW'(ITERS - 1))
                begin
                    state_next = S_MLO;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            S_MLO:   state_next = S_MHI;
            S_MHI:   state_next = S_DIST;
            S_DIST:  state_next = S_NUM;
            S_NUM:   state_next = S_ABS;
            S_ABS:   state_next = S_MULN;
            S_MULN:  state_next = S_DINIT;
            S_DINIT:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == DIV_CW'(LIN_W - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            iter_reg         <= '0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            target_valid_reg <= 1'b0;
            max_lin_reg      <= 20'd32768;
            ang_gain_reg     <= 20'd65536;
            min_dist_reg     <= 31'd32768;
            des_dist_reg     <= 31'd65536;
        end
        else
        begin
            state_reg        <= state_next;
            iter_reg         <= iter_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= out_valid_next;
            target_valid_reg <= target_valid_next;
            max_lin_reg      <= max_lin_next;
            ang_gain_reg     <= ang_gain_next;
            min_dist_reg     <= min_dist_next;
            des_dist_reg     <= des_dist_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser == pvc_pkg::OP_TARGET)
                    begin
                        target_x_reg <= s_tdata[31:0];
                        target_y_reg <= s_tdata[63:32];
                    end
                    else
                    begin
                        pos_x_reg <= s_tdata[31:0];
                        pos_y_reg <= s_tdata[63:32];
                    end
                end
            end
            // offset to the target
            S_DIFF:
            begin
                x_reg <= {{4{target_x_reg[31]}}, target_x_reg} - {{4{pos_x_reg[31]}}, pos_x_reg};
                y_reg <= {{4{target_y_reg[31]}}, target_y_reg} - {{4{pos_y_reg[31]}}, pos_y_reg};
                z_reg <= '0;
            end
            // quarter turn into the right half plane
            S_ROT:
            begin
                if (x_reg < 0)
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= y_reg;
                        y_reg <= -x_reg;
                        z_reg <= pvc_pkg::HALF_PI_Q30;
                    end
                    else
                    begin
                        x_reg <= -y_reg;
                        y_reg <= x_reg;
                        z_reg <= -pvc_pkg::HALF_PI_Q30;
                    end
                end
            end
            // vectoring step
            S_CORDIC:
            begin
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_step;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_step;
                end
            end
            // bearing clamp to +-pi
            S_MLO:
            begin
                if (z_reg > pvc_pkg::PI_Q30)
                begin
                    z_reg <= pvc_pkg::PI_Q30;
                end
                else if (z_reg < -pvc_pkg::PI_Q30)
                begin
                    z_reg <= -pvc_pkg::PI_Q30;
                end
            end
            S_MHI:
            begin
                acc_reg  <= prod;
                zneg_reg <= z_reg[ZW-1];
                zmag_reg <= z_reg[ZW-1] ? 32'(-z_reg) : z_reg[31:0];
            end
            S_DIST:
            begin
                d_reg <= dist_sum[63:30];
            end
            S_NUM:
            begin
                stop_reg <= (d_reg <= {3'b0, min_dist_reg});
                num_reg  <= $signed({1'b0, d_reg}) - $signed({4'b0, des_dist_reg});
            end
            S_ABS:
            begin
                lin_neg_reg <= num_reg[DW];
                nmag_reg    <= num_reg[DW] ? DW'(-num_reg) : num_reg[DW-1:0];
            end
            S_MULN:
            begin
                big_reg <= (nmag_reg >= d_reg);
            end
            // divider set-up: quotient fits in LIN_W bits unless clamped
            S_DINIT:
            begin
                rem_reg <= prod[PW-1:LIN_W];
                low_reg <= prod[LIN_W-1:0];
                quo_reg <= '0;
            end
            S_DIV:
            begin
                if (!trial[DW+1])
                begin
                    rem_reg <= trial[DW-1:0];
                    quo_reg <= {quo_reg[LIN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DW-2:0], low_reg[LIN_W-1]};
                    quo_reg <= {quo_reg[LIN_W-2:0], 1'b0};
                end
                low_reg <= {low_reg[LIN_W-2:0], 1'b0};
            end
            // result into the output register
            S_FIN:
            begin
                if (out_load)
                begin
                    out_data_reg <= stop_reg ? 64'd0 : {ang_val, lin_val};
                end
            end
            default:
            begin
                out_data_reg <= out_data_reg;
            end
        endcase
    end

    // checks
    `PVC_CHECK(a_cordic_x_pos, state_reg == S_CORDIC, !x_reg[XW-1])
    `PVC_CHECK(a_div_rem_below, (state_reg == S_DIV) && !big_reg, rem_reg < d_reg)
    `PVC_CHECK(a_no_target_no_work, state_reg != S_IDLE, target_valid_reg)
    `PVC_CHECK(a_lin_limit, m_tvalid && !m_tdata[31], m_tdata[31:0] <= 32'(max_lin_reg))

endmodule
